// File: rtl/core/plci_pkg.sv
// shared types and constants for the piecewise linear curve interpolator
package plci_pkg;

    localparam int DAY_W     = 20;
    localparam int RATE_W    = 32;
    localparam int IDX_W     = 4;
    localparam int KC_W      = 5;
    localparam int S_DATA_W  = 80;
    localparam int PROD_W    = 54;
    localparam int MAG_W     = PROD_W - 1;
    localparam int QUO_W     = RATE_W + 1;
    localparam int STEP_W    = $clog2(QUO_W + 1);
    localparam logic [KC_W-1:0] KNOT_COUNT_RST = KC_W'(16);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [DAY_W-1:0]         day;
        logic signed [RATE_W-1:0] rate;
    } knot_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

// File: rtl/core/plci_knot_mem.sv
// knot table: one write port, one read port with registered read data
module plci_knot_mem
    import plci_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  knot_t                    wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output knot_t                    rd_data
);

    knot_t mem [DEPTH];
    knot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/plci_div.sv
// radix-2 restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits
module plci_div
    import plci_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  dividend,
    input  logic [DAY_W-1:0]  divisor,
    output logic              done,
    output logic [QUO_W-1:0]  quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DAY_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DAY_W-1:0]  den_reg;

    logic [DAY_W:0]    trial;
    logic [DAY_W:0]    diff;
    logic              qbit;

    assign trial = {rem_reg, dvd_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(QUO_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // upper dividend bits are below the divisor since the quotient fits QUO_W bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[MAG_W-1:QUO_W];
            dvd_reg <= dividend[QUO_W-1:0];
            den_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= qbit ? diff[DAY_W-1:0] : trial[DAY_W-1:0];
            dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/piecewise_linear_curve_interp.sv
// Piecewise linear curve interpolator. A write beat (tuser 0) stores one knot (day, Q7.24
// rate) in the knot memory. A query beat (tuser 1) scans the segments from the highest
// one below knot_count downward, one memory read per segment, and for the first segment
// that encloses the day computes rate[k] + (rate[k+1]-rate[k])*(day-day[k]) /
// (day[k+1]-day[k]), truncated toward zero; equal knot days answer rate[k+1], and a day
// outside every segment answers 0 with in_range low. The knot memory has a single read
// port, and a query that needs a division runs the 33-step bit-serial divider. One item
// is worked on at a time; a finished result sits in the output register, so the next
// beat is taken while it waits. knot_count is written through cfg_wr_en / cfg_wr_data;
// it is to be written only between items, which the block itself does not enforce, and
// it resets to 16.
module piecewise_linear_curve_interp
    import plci_pkg::*;
#(
    parameter int MAX_KNOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [KC_W-1:0]     cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // knot_index, knot_day, knot_rate, query_day, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // op
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // rate_value
    output logic [RATE_W-1:0]   m_tdata,
    // in_range
    output logic                m_tuser
);

    localparam int AW  = $clog2(MAX_KNOTS);
    localparam int CW0 = $clog2(MAX_KNOTS + 1);
    localparam int CW  = (CW0 > KC_W) ? CW0 : KC_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FETCH  = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_DIVS   = 7'b0010000,
        ST_DIVW   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [KC_W-1:0]          cfg_count_reg;
    logic [AW-1:0]            seg_reg;
    logic [DAY_W-1:0]         day_reg;
    logic [DAY_W-1:0]         d1_reg;
    logic [DAY_W-1:0]         d0_reg;
    logic signed [RATE_W-1:0] r1_reg;
    logic signed [RATE_W-1:0] r0_reg;
    logic [DAY_W-1:0]         den_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [RATE_W-1:0]        res_reg;
    logic                     found_reg;
    logic                     m_valid_reg;
    logic [RATE_W-1:0]        m_rate_reg;
    logic                     m_inr_reg;

    logic [IDX_W-1:0]         in_index;
    knot_t                    in_knot;
    logic [DAY_W-1:0]         in_qday;
    logic                     s_beat;
    logic                     wr_en;
    logic [AW-1:0]            rd_addr;
    knot_t                    rd_data;

    logic [CW-1:0]            cnt_ext;
    logic [CW-1:0]            cnt_eff;
    logic                     hit;
    logic signed [RATE_W:0]   rate_diff;
    logic signed [DAY_W:0]    day_off;
    logic [PROD_W-1:0]        prod_mag;
    logic [QUO_W:0]           q_signed;
    logic [QUO_W:0]           res_wide;
    logic                     out_free;
    div_ctrl_t                div_ctrl;
    logic [QUO_W-1:0]         quotient;

    assign in_index     = s_tdata[IDX_W-1:0];
    assign in_knot.day  = s_tdata[IDX_W +: DAY_W];
    assign in_knot.rate = s_tdata[IDX_W+DAY_W +: RATE_W];
    assign in_qday      = s_tdata[IDX_W+DAY_W+RATE_W +: DAY_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign wr_en    = s_beat && (s_tuser == OP_WRITE)
                      && (32'(in_index) < 32'(MAX_KNOTS));

    assign cnt_ext = CW'(cfg_count_reg);
    assign cnt_eff = (cnt_ext > CW'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : cnt_ext;

    assign hit       = (rd_data.day <= day_reg) && (day_reg <= d1_reg);
    assign rate_diff = {r1_reg[RATE_W-1], r1_reg} - {r0_reg[RATE_W-1], r0_reg};
    assign day_off   = $signed({1'b0, day_reg - d0_reg});
    assign prod_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : prod_reg;
    assign q_signed  = prod_reg[PROD_W-1] ? -{1'b0, quotient} : {1'b0, quotient};
    assign res_wide  = {{(QUO_W+1-RATE_W){r0_reg[RATE_W-1]}}, r0_reg} + q_signed;
    assign out_free  = !m_valid_reg || m_tready;

    assign div_ctrl.start = (state_reg == ST_DIVS);

    always_comb begin
        unique case (state_reg)
            ST_IDLE:   rd_addr = AW'(cnt_eff - CW'(1));
            ST_SEARCH: rd_addr = seg_reg - AW'(1);
            default:   rd_addr = seg_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat && (s_tuser == OP_QUERY)) begin
                    state_next = (cnt_eff < CW'(2)) ? ST_DONE : ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_SEARCH;
            ST_SEARCH: begin
                if (hit) begin
                    state_next = (rd_data.day == d1_reg) ? ST_DONE : ST_MUL;
                end else if (seg_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:  state_next = ST_DIVS;
            ST_DIVS: state_next = ST_DIVW;
            ST_DIVW: begin
                if (div_ctrl.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_count_reg <= KNOT_COUNT_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cfg_count_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                day_reg   <= in_qday;
                seg_reg   <= AW'(cnt_eff - CW'(2));
                found_reg <= 1'b0;
                res_reg   <= '0;
            end
            ST_FETCH: begin
                d1_reg <= rd_data.day;
                r1_reg <= rd_data.rate;
            end
            ST_SEARCH: begin
                if (hit) begin
                    found_reg <= 1'b1;
                    d0_reg    <= rd_data.day;
                    r0_reg    <= rd_data.rate;
                    res_reg   <= r1_reg;
                end else begin
                    // slide down one segment: the lower knot becomes the upper one
                    d1_reg  <= rd_data.day;
                    r1_reg  <= rd_data.rate;
                    seg_reg <= seg_reg - AW'(1);
                end
            end
            ST_MUL: begin
                prod_reg <= rate_diff * day_off;
                den_reg  <= d1_reg - d0_reg;
            end
            ST_DIVW: begin
                if (div_ctrl.done) begin
                    res_reg <= res_wide[RATE_W-1:0];
                end
            end
            default: begin
            end
        endcase
        if ((state_reg == ST_DONE) && out_free) begin
            m_rate_reg <= res_reg;
            m_inr_reg  <= found_reg;
        end
    end

    plci_knot_mem #(
        .DEPTH(MAX_KNOTS)
    ) u_knot_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_index)),
        .wr_data (in_knot),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    plci_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_ctrl.start),
        .dividend (prod_mag[MAG_W-1:0]),
        .divisor  (den_reg),
        .done     (div_ctrl.done),
        .quotient (quotient)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_rate_reg;
    assign m_tuser  = m_inr_reg;

endmodule
